>>> sv/r2p_pkg.sv
// Shared types, constants and the arctangent table for the rectangular to polar core.
// No dependencies; every other file of the block imports this package.
package r2p_pkg;

    // Fixed internal formats of the angle datapath.
    localparam int QBITS        = 60;          // fraction bits of internal angles
    localparam int ITERS        = 62;          // rotation cells in the chain
    localparam int NORM_STAGES  = 6;           // normalize cells, shifts 32 down to 1
    localparam int CVW          = QBITS + 4;   // signed word of the rotation cells
    localparam int THW          = QBITS + 2;   // unsigned angle word, holds pi
    localparam int OUT_FIELD_W  = 16;          // width of each result field

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // Control word that travels beside the data through every normalize and rotation cell.
    typedef struct packed {
        logic valid;
        logic xneg;
        logic yneg;
        logic zero;
    } r2p_ctl_t;

    // Operands of the normalize cells, all below 2**QBITS.
    typedef struct packed {
        logic [QBITS-1:0] m;
        logic [QBITS-1:0] ax;
        logic [QBITS-1:0] ay;
    } r2p_norm_t;

    // Vector and accumulated angle of the rotation cells.
    typedef struct packed {
        logic signed [CVW-1:0] x;
        logic signed [CVW-1:0] y;
        logic signed [CVW-1:0] z;
    } r2p_vec_t;

    // Shift-and-subtract division, used only while the constant table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Series for atan(1/m) scaled by 2**QBITS, truncated the same way at every term.
    function automatic logic [63:0] atan_inv(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] k;
        p   = udiv64(64'd1 << QBITS, m);
        sum = '0;
        k   = '0;
        for (int j = 0; j < 64; j++) begin
            if (p != 64'd0) begin
                t = udiv64(p, 64'd2 * k + 64'd1);
                if (k[0] == 1'b0) begin
                    sum = sum + t;
                end else begin
                    sum = sum - t;
                end
                p = udiv64(p, m * m);
                k = k + 64'd1;
            end
        end
        return sum;
    endfunction

    // Pi by Machin's formula, scaled by 2**QBITS.
    localparam logic [63:0] PI_Q = 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);

    // Rotation angle atan(2**-i) of cell i, scaled by 2**QBITS.
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        int          e;
        sum = '0;
        if (i == 0) begin
            sum = PI_Q >> 2;
        end else begin
            for (int k = 0; k < QBITS; k++) begin
                e = i * (2 * k + 1);
                if (e <= QBITS) begin
                    t = udiv64(64'd1 << (QBITS - e), 64'(2 * k + 1));
                    if ((k & 1) == 0) begin
                        sum = sum + t;
                    end else begin
                        sum = sum - t;
                    end
                end
            end
        end
        return sum;
    endfunction

    // Shift applied by normalize cell j.
    function automatic int norm_shift(input int j);
        return 1 << (NORM_STAGES - 1 - j);
    endfunction

endpackage

>>> sv/r2p_norm_cell.sv
// One normalize cell: shifts the operands left by a fixed amount when that keeps
// the larger one below 2**QBITS. Depends on r2p_pkg.
module r2p_norm_cell
    import r2p_pkg::*;
#(
    parameter int SHIFT = 1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  r2p_ctl_t  ctl_i,
    input  r2p_norm_t data_i,
    output r2p_ctl_t  ctl_o,
    output r2p_norm_t data_o
);

    r2p_ctl_t  ctl_reg;
    r2p_norm_t data_reg;
    r2p_norm_t data_next;

    always_comb begin
        data_next = data_i;
        if (data_i.m[QBITS-1 -: SHIFT] == '0) begin
            data_next.m  = data_i.m << SHIFT;
            data_next.ax = data_i.ax << SHIFT;
            data_next.ay = data_i.ay << SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign ctl_o  = ctl_reg;
    assign data_o = data_reg;

endmodule

>>> sv/r2p_cordic_cell.sv
// One vectoring rotation cell of the chain: rotates toward the x axis by atan(2**-ITER)
// and accumulates the angle. Depends on r2p_pkg for the table and types.
module r2p_cordic_cell
    import r2p_pkg::*;
#(
    parameter int ITER = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  r2p_ctl_t ctl_i,
    input  r2p_vec_t vec_i,
    output r2p_ctl_t ctl_o,
    output r2p_vec_t vec_o
);

    localparam logic [CVW-1:0] ATAN = CVW'(atan_entry(ITER));

    r2p_ctl_t ctl_reg;
    r2p_vec_t vec_reg;
    r2p_vec_t vec_next;
    logic signed [CVW-1:0] xs;
    logic signed [CVW-1:0] ys;

    always_comb begin
        xs = vec_i.x >>> ITER;
        ys = vec_i.y >>> ITER;
        if (vec_i.y >= 0) begin
            vec_next.x = vec_i.x + ys;
            vec_next.y = vec_i.y - xs;
            vec_next.z = vec_i.z + $signed(ATAN);
        end else begin
            vec_next.x = vec_i.x - ys;
            vec_next.y = vec_i.y + xs;
            vec_next.z = vec_i.z - $signed(ATAN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign vec_o = vec_reg;

endmodule

>>> sv/r2p_sqrt_cell.sv
// One digit cell of the integer square root: brings in two radicand bits and
// settles one root bit. Depends on r2p_pkg for the default coordinate width.
module r2p_sqrt_cell
    import r2p_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [2*COORD_WIDTH-1:0] rad_i,
    input  logic [COORD_WIDTH+1:0]   rem_i,
    input  logic [COORD_WIDTH-1:0]   root_i,
    output logic [2*COORD_WIDTH-1:0] rad_o,
    output logic [COORD_WIDTH+1:0]   rem_o,
    output logic [COORD_WIDTH-1:0]   root_o
);

    localparam int W = COORD_WIDTH;

    logic [2*W-1:0] rad_reg;
    logic [W+1:0]   rem_reg;
    logic [W-1:0]   root_reg;
    logic [2*W-1:0] rad_next;
    logic [W+1:0]   rem_next;
    logic [W-1:0]   root_next;
    logic [W+1:0]   partial;
    logic [W+1:0]   trial;

    // The remainder before this digit is below 2**W, so its low bits carry it all.
    always_comb begin
        partial  = {rem_i[W-1:0], rad_i[2*W-1 -: 2]};
        trial    = {root_i, 2'b01};
        rad_next = {rad_i[2*W-3:0], 2'b00};
        if (partial >= trial) begin
            rem_next  = partial - trial;
            root_next = {root_i[W-2:0], 1'b1};
        end else begin
            rem_next  = partial;
            root_next = {root_i[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

>>> sv/rect_to_polar_convert_core.sv
// Top level of the rectangular to polar converter: input stages, the normalize,
// rotation and square root cell chains, angle mapping and the output skid buffer.
// Depends on r2p_pkg, r2p_norm_cell, r2p_cordic_cell and r2p_sqrt_cell.

// Each request on the input stream carries one point (x, y) of signed coordinates and
// yields exactly one result: the distance from the origin, rounded to the nearest
// integer, and atan2(y, x) in radians as a signed fixed-point value with
// ANGLE_FRAC_BITS fraction bits (pi = 25736 at 13 bits), within plus and minus pi. The
// origin gives zero for both. The core takes one point in every cycle unless the skid
// entry is full; its throughput is set by the fully unrolled chain of cells, in which
// every normalize, rotation and root digit step has a cell of its own. An accepted
// request passes three input stages, six normalize cells, 62 rotation cells, two angle
// mapping stages and the output register on its way out. The square root runs in
// COORD_WIDTH digit cells beside the rotation chain, and its result is delayed to meet
// the angle. A two-entry output stage (register plus skid) lets the chain move on while
// a result waits, so s_tready drops only once both entries are full. No clearing pass
// or warm-up is needed after reset.
module rect_to_polar_convert_core
    import r2p_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: x_coord, y_coord, zero padding to whole bytes.
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0 up: magnitude (unsigned), angle (signed).
    output logic [2*OUT_FIELD_W-1:0]               m_tdata
);

    localparam int W          = COORD_WIDTH;
    localparam int SH         = QBITS - ANGLE_FRAC_BITS;
    localparam int AW         = THW - SH;
    localparam int MAG_STAGES = NORM_STAGES + ITERS + 2 - W;
    localparam logic [THW-1:0] PI_T = PI_Q[THW-1:0];
    localparam logic [THW-1:0] HALF = THW'(64'd1 << (SH - 1));

    // The whole chain advances together; it stops only while the skid entry is full.
    logic en;

    // Input stage: absolute values and sign flags.
    logic [W-1:0] x_in;
    logic [W-1:0] y_in;
    r2p_ctl_t     s1_ctl_reg;
    r2p_ctl_t     s1_ctl_next;
    logic [W-1:0] s1_ax_reg;
    logic [W-1:0] s1_ay_reg;
    logic [W-1:0] s1_ax_next;
    logic [W-1:0] s1_ay_next;

    // Second stage: squares and the larger operand.
    r2p_ctl_t       s2_ctl_reg;
    logic [2*W-1:0] s2_xx_reg;
    logic [2*W-1:0] s2_yy_reg;
    logic [W-1:0]   s2_ax_reg;
    logic [W-1:0]   s2_ay_reg;
    logic [W-1:0]   s2_m_reg;
    logic [W-1:0]   s2_m_next;

    // Third stage: sum of squares.
    r2p_ctl_t       s3_ctl_reg;
    logic [2*W-1:0] s3_sum_reg;
    logic [W-1:0]   s3_ax_reg;
    logic [W-1:0]   s3_ay_reg;
    logic [W-1:0]   s3_m_reg;

    // Cell chains.
    r2p_ctl_t  norm_ctl [0:NORM_STAGES];
    r2p_norm_t norm_dat [0:NORM_STAGES];
    r2p_ctl_t  rot_ctl  [0:ITERS];
    r2p_vec_t  rot_vec  [0:ITERS];

    logic [2*W-1:0] sq_rad  [0:W];
    logic [W+1:0]   sq_rem  [0:W];
    logic [W-1:0]   sq_root [0:W];

    logic [W-1:0] mag_pipe_reg [0:MAG_STAGES-1];
    logic [W-1:0] mag_round;

    // Angle mapping stages.
    r2p_ctl_t        f1_ctl_reg;
    logic [THW-1:0]  f1_theta_reg;
    logic [THW-1:0]  f1_theta_next;
    logic [THW-1:0]  z_clamp;
    r2p_ctl_t        f2_ctl_reg;
    logic [AW-1:0]   f2_ang_reg;
    logic [THW-1:0]  f2_sum;

    // Result assembly and output stage.
    logic [AW+15:0]            ang_ext;
    logic [AW+15:0]            ang_signed;
    logic [W+15:0]             mag_ext;
    logic [OUT_FIELD_W-1:0]    fin_angle;
    logic [2*OUT_FIELD_W-1:0]  fin_data;
    logic                      fin_valid;
    logic                      take_out;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [2*OUT_FIELD_W-1:0]  m_data_reg;
    logic [2*OUT_FIELD_W-1:0]  m_data_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    logic [2*OUT_FIELD_W-1:0]  skid_data_reg;
    logic [2*OUT_FIELD_W-1:0]  skid_data_next;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Input stages
    // ------------------------------------------------------------------
    assign x_in = s_tdata[W-1:0];
    assign y_in = s_tdata[2*W-1:W];

    // The most negative coordinate has magnitude 2**(W-1), which still fits in W bits.
    always_comb begin
        s1_ctl_next.valid = s_tvalid;
        s1_ctl_next.xneg  = x_in[W-1];
        s1_ctl_next.yneg  = y_in[W-1];
        s1_ctl_next.zero  = (x_in == '0) && (y_in == '0);
        s1_ax_next        = x_in[W-1] ? (W'(0) - x_in) : x_in;
        s1_ay_next        = y_in[W-1] ? (W'(0) - y_in) : y_in;
        s2_m_next         = (s1_ax_reg > s1_ay_reg) ? s1_ax_reg : s1_ay_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ax_reg  <= s1_ax_next;
            s1_ay_reg  <= s1_ay_next;
            s2_xx_reg  <= s1_ax_reg * s1_ax_reg;
            s2_yy_reg  <= s1_ay_reg * s1_ay_reg;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_m_reg   <= s2_m_next;
            s3_sum_reg <= s2_xx_reg + s2_yy_reg;
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_m_reg   <= s2_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Normalize cells: bring the larger operand into [2**(QBITS-1), 2**QBITS).
    // ------------------------------------------------------------------
    assign norm_ctl[0]    = s3_ctl_reg;
    assign norm_dat[0].m  = {(QBITS-W)'(0), s3_m_reg};
    assign norm_dat[0].ax = {(QBITS-W)'(0), s3_ax_reg};
    assign norm_dat[0].ay = {(QBITS-W)'(0), s3_ay_reg};

    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
        r2p_norm_cell #(
            .SHIFT (norm_shift(j))
        ) u_norm (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (norm_ctl[j]),
            .data_i  (norm_dat[j]),
            .ctl_o   (norm_ctl[j+1]),
            .data_o  (norm_dat[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Rotation cells in vectoring mode on the first-quadrant point.
    // ------------------------------------------------------------------
    assign rot_ctl[0]   = norm_ctl[NORM_STAGES];
    assign rot_vec[0].x = {(CVW-QBITS)'(0), norm_dat[NORM_STAGES].ax};
    assign rot_vec[0].y = {(CVW-QBITS)'(0), norm_dat[NORM_STAGES].ay};
    assign rot_vec[0].z = '0;

    for (genvar i = 0; i < ITERS; i++) begin : g_rot
        r2p_cordic_cell #(
            .ITER (i)
        ) u_rot (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (rot_ctl[i]),
            .vec_i   (rot_vec[i]),
            .ctl_o   (rot_ctl[i+1]),
            .vec_o   (rot_vec[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Square root digit cells, rounding, and the delay that meets the angle.
    // ------------------------------------------------------------------
    assign sq_rad[0]  = s3_sum_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        r2p_sqrt_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_sqrt (
            .aclk    (aclk),
            .en      (en),
            .rad_i   (sq_rad[k]),
            .rem_i   (sq_rem[k]),
            .root_i  (sq_root[k]),
            .rad_o   (sq_rad[k+1]),
            .rem_o   (sq_rem[k+1]),
            .root_o  (sq_root[k+1])
        );
    end

    // Round up when the remainder exceeds the root; a tie cannot occur.
    assign mag_round = sq_root[W] + W'(sq_rem[W] > {2'b00, sq_root[W]});

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_pipe_reg[0] <= mag_round;
            for (int i = 1; i < MAG_STAGES; i++) begin
                mag_pipe_reg[i] <= mag_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle mapping: clamp, reflect for negative x, then round to the output grid.
    // ------------------------------------------------------------------
    always_comb begin
        z_clamp = rot_vec[ITERS].z[CVW-1] ? '0 : rot_vec[ITERS].z[THW-1:0];
        if (rot_ctl[ITERS].xneg) begin
            f1_theta_next = (z_clamp > PI_T) ? '0 : (PI_T - z_clamp);
        end else begin
            f1_theta_next = z_clamp;
        end
        f2_sum = f1_theta_reg + HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_ctl_reg <= '0;
            f2_ctl_reg <= '0;
        end else if (en) begin
            f1_ctl_reg <= rot_ctl[ITERS];
            f2_ctl_reg <= f1_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_theta_reg <= f1_theta_next;
            f2_ang_reg   <= f2_sum[THW-1:SH];
        end
    end

    // The angle is rounded on its absolute value and negated for negative y, so the
    // result is symmetric about the x axis. Both fields keep their low 16 bits.
    always_comb begin
        ang_ext    = {16'(0), f2_ang_reg};
        ang_signed = f2_ctl_reg.yneg ? ((AW+16)'(0) - ang_ext) : ang_ext;
        fin_angle  = f2_ctl_reg.zero ? '0 : ang_signed[OUT_FIELD_W-1:0];
        mag_ext    = {16'(0), mag_pipe_reg[MAG_STAGES-1]};
        fin_data   = {fin_angle, mag_ext[OUT_FIELD_W-1:0]};
        fin_valid  = f2_ctl_reg.valid;
    end

    // ------------------------------------------------------------------
    // Output register with skid entry.
    // ------------------------------------------------------------------
    always_comb begin
        take_out        = !m_valid_reg || m_tready;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (take_out && skid_valid_reg) begin
            m_valid_next    = 1'b1;
            m_data_next     = skid_data_reg;
            skid_valid_next = 1'b0;
        end else if (take_out) begin
            m_valid_next = fin_valid;
            m_data_next  = fin_data;
        end else if (fin_valid && !skid_valid_reg) begin
            // Output is held; the result leaving the chain parks in the skid entry.
            // With the skid entry full the chain is stopped and the result stays put.
            skid_valid_next = 1'b1;
            skid_data_next  = fin_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid entry fills only behind a held output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry full while output register is empty");

    // A taken output is refilled from the skid entry at once.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (m_valid_reg && !skid_valid_reg))
        else $error("skid entry did not drain into the output register");

    // The mapped angle never leaves the range zero to pi.
    a_theta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        f1_ctl_reg.valid |-> (f1_theta_reg <= PI_T))
        else $error("mapped angle exceeds pi");

    // The origin gives an all-zero result when it goes straight to the output.
    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid && f2_ctl_reg.zero && take_out && !skid_valid_reg)
            |=> (m_tdata == '0))
        else $error("origin did not give zero magnitude and angle");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for rect_to_polar_convert_core: streams points in, checks magnitude and angle.
// Depends on r2p_pkg and the core; holds its own bit-exact model of the converter.
module tb;
    import r2p_pkg::*;

    localparam int COORD_W     = 16;
    localparam int ANG_FRAC    = 13;
    localparam int ANG_SHIFT   = 60 - ANG_FRAC;
    localparam int S_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int RAND_POINTS = 1750;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                      drain;   // wait for all results before this request
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_req_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [15:0]               mag;
        logic [15:0]               ang;
    } polar_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*OUT_FIELD_W-1:0] m_tdata;

    point_req_t pending_points[$];
    polar_t     polar_due[$];

    longint unsigned rot_angle[62];
    longint unsigned pi_q60;

    int   cycle_count = 0;
    int   bad_results = 0;
    int   tx_rate     = 2;
    int   rx_rate     = 2;
    int   tx_gap      = 0;
    int   rx_stall    = 0;
    logic in_taken    = 1'b0;
    logic calm        = 1'b0;

    rect_to_polar_convert_core #(
        .COORD_WIDTH    (COORD_W),
        .ANGLE_FRAC_BITS(ANG_FRAC)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // atan(1/m) in Q60 by its power series, each term truncated.
    function automatic longint unsigned arctan_recip(longint unsigned m);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned k;
        p   = (64'd1 << 60) / m;
        acc = 0;
        k   = 0;
        while (p != 0) begin
            if (k[0]) begin
                acc = acc - p / (2 * k + 1);
            end else begin
                acc = acc + p / (2 * k + 1);
            end
            p = p / (m * m);
            k = k + 1;
        end
        return acc;
    endfunction

    function automatic void build_rot_angles();
        longint unsigned acc;
        int              e;
        pi_q60       = 16 * arctan_recip(5) - 4 * arctan_recip(239);
        rot_angle[0] = pi_q60 / 4;
        for (int i = 1; i < 62; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                e = i * (2 * k + 1);
                if (k % 2 == 0) begin
                    acc = acc + (64'd1 << (60 - e)) / 64'(2 * k + 1);
                end else begin
                    acc = acc - (64'd1 << (60 - e)) / 64'(2 * k + 1);
                end
            end
            rot_angle[i] = acc;
        end
    endfunction

    // Vectoring rotations on a first-quadrant point scaled up to about 2^59.
    function automatic longint unsigned first_quadrant_angle(longint unsigned ax,
                                                              longint unsigned ay);
        longint unsigned big;
        longint          cx;
        longint          cy;
        longint          nx;
        longint          z;
        big = (ax > ay) ? ax : ay;
        while (big < (64'd1 << 59)) begin
            big = big << 1;
            ax  = ax << 1;
            ay  = ay << 1;
        end
        cx = longint'(ax);
        cy = longint'(ay);
        z  = 0;
        for (int i = 0; i < 62; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + longint'(rot_angle[i]);
            end else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - longint'(rot_angle[i]);
            end
            cx = nx;
        end
        if (z < 0) begin
            z = 0;
        end
        return longint'(z);
    endfunction

    function automatic polar_t polar_of(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        polar_t          res;
        longint          sx;
        longint          sy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned theta;
        longint unsigned a;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;

        // Floor square root bit by bit, then round on the remainder.
        sq   = ax * ax + ay * ay;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        if (sq - root * root > root) begin
            root = root + 1;
        end

        if (ax == 0 && ay == 0) begin
            a = 0;
        end else begin
            theta = first_quadrant_angle(ax, ay);
            if (sx < 0) begin
                theta = (theta > pi_q60) ? 0 : pi_q60 - theta;
            end
            // Rounded on the absolute angle so the result is symmetric in y.
            a = (theta + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
            if (sy < 0) begin
                a = -a;
            end
        end
        res.x   = x;
        res.y   = y;
        res.mag = root[15:0];
        res.ang = a[15:0];
        return res;
    endfunction

    function automatic void add_point(logic drain, int x, int y);
        point_req_t p;
        p.drain = drain;
        p.x     = x[COORD_W-1:0];
        p.y     = y[COORD_W-1:0];
        pending_points.push_back(p);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // Sender: presents the next point at the falling edge, with bursts of idle cycles.
    always @(negedge aclk) begin
        point_req_t nxt;
        logic                drive_v;
        logic [S_DATA_W-1:0] drive_d;
        drive_v = s_tvalid;
        drive_d = s_tdata;
        if (aresetn) begin
            if (in_taken) begin
                drive_v = 1'b0;
            end
            calm = (pending_points.size() <= CALM_TAIL);
            if (!drive_v) begin
                if (tx_gap != 0) begin
                    tx_gap = tx_gap - 1;
                end else if (pending_points.size() != 0 &&
                             !(pending_points[0].drain && polar_due.size() != 0)) begin
                    nxt     = pending_points.pop_front();
                    drive_v = 1'b1;
                    drive_d = '0;
                    drive_d[2*COORD_W-1:0] = {nxt.y, nxt.x};
                    if (!calm && $urandom_range(15, 0) < tx_rate) begin
                        tx_gap = $urandom_range(18, 1);
                    end
                end
            end
        end
        s_tvalid <= drive_v;
        s_tdata  <= drive_d;
    end

    // Receiver: backpressure in bursts, none once the run is in its tail.
    always @(negedge aclk) begin
        logic ready;
        ready = 1'b1;
        if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            ready    = 1'b0;
        end else if (!calm && $urandom_range(15, 0) < rx_rate) begin
            rx_stall = $urandom_range(18, 1) - 1;
            ready    = 1'b0;
        end
        m_tready <= ready;
    end

    // Monitor: models each accepted request and checks results in order.
    always @(posedge aclk) begin
        polar_t want;
        cycle_count = cycle_count + 1;
        // Idle density changes now and then; a rate of zero gives a clean stretch.
        if (cycle_count % 256 == 0) begin
            tx_rate = $urandom_range(4, 0);
            rx_rate = $urandom_range(4, 0);
        end
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            polar_due.push_back(polar_of(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W]));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (polar_due.size() == 0) begin
                if (bad_results < 10) begin
                    $display("unexpected result: magnitude %0d angle %0d",
                             m_tdata[15:0], $signed(m_tdata[31:16]));
                end
                bad_results = bad_results + 1;
            end else begin
                want = polar_due.pop_front();
                if (m_tdata[15:0] !== want.mag || m_tdata[31:16] !== want.ang) begin
                    if (bad_results < 10) begin
                        $display("mismatch at (%0d, %0d): magnitude exp %0d got %0d, %s%0d got %0d",
                                 want.x, want.y, want.mag, m_tdata[15:0], "angle exp ",
                                 $signed(want.ang), $signed(m_tdata[31:16]));
                    end
                    bad_results = bad_results + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int kind;
        int x;
        int y;
        build_rot_angles();

        // Origin, axes, corners, the negative x axis and points next to the pi cut.
        add_point(1'b0, 0, 0);
        add_point(1'b0, 32767, 0);
        add_point(1'b0, -32768, 0);
        add_point(1'b0, 0, 32767);
        add_point(1'b0, 0, -32768);
        add_point(1'b0, 32767, 32767);
        add_point(1'b0, -32768, -32768);
        add_point(1'b0, -32768, 32767);
        add_point(1'b0, 32767, -32768);
        add_point(1'b0, -1, 0);
        add_point(1'b0, -5, 0);
        add_point(1'b0, 1, 0);
        add_point(1'b0, 0, 1);
        add_point(1'b0, 0, -1);
        add_point(1'b0, 1, 1);
        add_point(1'b0, -1, -1);
        add_point(1'b0, -1, 1);
        add_point(1'b0, 1, -1);
        add_point(1'b0, -32768, 1);
        add_point(1'b0, -32768, -1);
        add_point(1'b0, 3, 4);
        add_point(1'b0, -3, -4);
        add_point(1'b0, -1, -32768);

        for (int n = 0; n < RAND_POINTS; n++) begin
            kind = $urandom_range(9, 0);
            case (kind)
                4: begin
                    x = $urandom_range(32, 0) - 16;
                    y = $urandom_range(32, 0) - 16;
                end
                5: begin
                    x = ($urandom_range(1, 0) == 1) ? rand_coord() : 0;
                    y = (x == 0) ? rand_coord() : 0;
                end
                6: begin
                    x = ($urandom_range(1, 0) == 1) ? -32768 : 32767;
                    y = ($urandom_range(2, 0) == 0) ? rand_coord()
                        : (($urandom_range(1, 0) == 1) ? -32768 : 32767);
                end
                7: begin
                    // Negative x with a tiny y lands right beside plus or minus pi.
                    x = -$urandom_range(32768, 1);
                    y = $urandom_range(4, 0) - 2;
                end
                8: begin
                    x = rand_coord();
                    y = ($urandom_range(1, 0) == 1) ? x : -x;
                    y = y + $urandom_range(2, 0) - 1;
                    if (y > 32767) begin
                        y = 32767;
                    end
                end
                9: begin
                    x = rand_coord() >>> $urandom_range(14, 0);
                    y = rand_coord() >>> $urandom_range(14, 0);
                end
                default: begin
                    x = rand_coord();
                    y = rand_coord();
                end
            endcase
            add_point(n == 0 || n == RAND_POINTS / 2, x, y);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_points.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (polar_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (bad_results == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
